// File: hdl/ogg_pv_pkg.sv
// ----------------------------------------------------------------------------
// ogg_pv_pkg
// Shared constants, codes and types of the Ogg page validator.
// ----------------------------------------------------------------------------
package ogg_pv_pkg;

	// parse phases
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_LACING = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;
	localparam logic [1:0] PH_IGNORE = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_CAPTURE  = 3'd1;
	localparam logic [2:0] ST_VERSION  = 3'd2;
	localparam logic [2:0] ST_TRUNC    = 3'd3;
	localparam logic [2:0] ST_MISMATCH = 3'd4;

	// header layout
	localparam logic [8:0] HDR_FIXED = 9'd27;
	localparam logic [8:0] VER_POS   = 9'd4;
	localparam logic [8:0] CRC_LO    = 9'd22;
	localparam logic [8:0] CRC_HI    = 9'd25;
	localparam logic [8:0] SEG_POS   = 9'd26;

	localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

	// stream position wraps at the buffer size limit
	localparam int          POS_W            = 24;
	localparam longint      MAX_BUFFER_BYTES = 64'd16777216;
	localparam logic [POS_W-1:0] POS_LAST    = POS_W'(MAX_BUFFER_BYTES - 64'd1);

	// one result beat
	typedef struct packed {
		logic             valid;
		logic [2:0]       status;
		logic [POS_W-1:0] page_offset;
		logic [8:0]       header_length;
		logic [15:0]      body_length;
		logic             buffer_done;
	} res_t;

	// expected capture pattern byte "OggS"
	function automatic logic [7:0] capture_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'h4F;
			2'd1: b = 8'h67;
			2'd2: b = 8'h67;
			default: b = 8'h53;
		endcase
		return b;
	endfunction

endpackage

// File: hdl/ogg_pv_crc.sv
// ----------------------------------------------------------------------------
// ogg_pv_crc
// One byte step of the Ogg CRC-32 (poly 04C11DB7, MSB first, no reflection).
// ----------------------------------------------------------------------------
module ogg_pv_crc
	import ogg_pv_pkg::*;
(
	input  logic [31:0] crc_in,
	input  logic [7:0]  data,
	output logic [31:0] crc_out
);

	always_comb begin
		logic [31:0] c;
		c = crc_in ^ {data, 24'd0};
		for (int k = 0; k < 8; k++) begin
			if (c[31]) begin
				c = {c[30:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[30:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

// File: hdl/ogg_pv_parse.sv
// ----------------------------------------------------------------------------
// ogg_pv_parse
// Page parser state: header checks, lacing sum, body count and CRC compare.
// ----------------------------------------------------------------------------
module ogg_pv_parse
	import ogg_pv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output res_t       res
);

	logic [1:0]       phase_q, phase_d;
	logic [8:0]       hidx_q, hidx_d;
	logic [7:0]       seg_q, seg_d;
	logic [15:0]      bsum_q, bsum_d;
	logic [15:0]      bleft_q, bleft_d;
	logic [31:0]      crc_q, crc_d;
	logic [31:0]      stored_q, stored_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] pstart_q, pstart_d;

	logic        page_open;
	logic [31:0] crc_base, crc_next;
	logic [7:0]  feed_byte;
	logic        in_crc_field;
	logic [8:0]  hlen_d;
	logic [15:0] bleft_dec;

	assign page_open    = (phase_q == PH_HEADER) && (hidx_q == 9'd0);
	assign in_crc_field = (phase_q == PH_HEADER) && (hidx_q >= CRC_LO) && (hidx_q <= CRC_HI);
	assign crc_base     = page_open ? 32'd0 : crc_q;
	assign feed_byte    = in_crc_field ? 8'd0 : data_byte;

	ogg_pv_crc u_crc (
		.crc_in  (crc_base),
		.data    (feed_byte),
		.crc_out (crc_next)
	);

	assign bleft_dec = (bleft_q != 16'd0) ? bleft_q - 16'd1 : bleft_q;

	always_comb begin
		phase_d  = phase_q;
		hidx_d   = hidx_q;
		seg_d    = seg_q;
		bsum_d   = bsum_q;
		bleft_d  = bleft_q;
		crc_d    = crc_q;
		stored_d = page_open ? 32'd0 : stored_q;
		pos_d    = pos_q;
		pstart_d = page_open ? pos_q : pstart_q;
		hlen_d   = HDR_FIXED + {1'b0, seg_q};

		res             = '0;
		res.page_offset = pstart_d;
		res.buffer_done = last_byte;

		unique case (phase_q)
			PH_HEADER: begin
				if (hidx_q < VER_POS && data_byte != capture_byte(hidx_q[1:0])) begin
					res.valid  = 1'b1;
					res.status = ST_CAPTURE;
					phase_d    = PH_IGNORE;
				end else if (hidx_q == VER_POS && data_byte != 8'd0) begin
					res.valid  = 1'b1;
					res.status = ST_VERSION;
					phase_d    = PH_IGNORE;
				end else begin
					crc_d = crc_next;
					if (in_crc_field) begin
						case (hidx_q[1:0] ^ 2'b10)
							2'd0: stored_d[7:0]   = data_byte;
							2'd1: stored_d[15:8]  = data_byte;
							2'd2: stored_d[23:16] = data_byte;
							default: stored_d[31:24] = data_byte;
						endcase
					end
					if (hidx_q >= SEG_POS) begin
						seg_d  = data_byte;
						hidx_d = HDR_FIXED;
						bsum_d = 16'd0;
						hlen_d = HDR_FIXED + {1'b0, data_byte};
						if (data_byte == 8'd0) begin
							bleft_d = 16'd0;
							// empty page: finish right on the count byte
							res.valid         = 1'b1;
							res.status        = (crc_next == stored_d) ? ST_OK : ST_MISMATCH;
							res.header_length = hlen_d;
							res.body_length   = 16'd0;
						end else begin
							phase_d = PH_LACING;
						end
					end else begin
						hidx_d = hidx_q + 9'd1;
					end
				end
			end
			PH_LACING: begin
				crc_d  = crc_next;
				bsum_d = bsum_q + {8'd0, data_byte};
				hidx_d = hidx_q + 9'd1;
				if (hidx_d >= hlen_d) begin
					bleft_d = bsum_d;
					if (bsum_d == 16'd0) begin
						res.valid         = 1'b1;
						res.status        = (crc_next == stored_q) ? ST_OK : ST_MISMATCH;
						res.header_length = hlen_d;
						res.body_length   = bsum_d;
					end else begin
						phase_d = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				crc_d   = crc_next;
				bleft_d = bleft_dec;
				if (bleft_dec == 16'd0) begin
					res.valid         = 1'b1;
					res.status        = (crc_next == stored_q) ? ST_OK : ST_MISMATCH;
					res.header_length = hlen_d;
					res.body_length   = bsum_q;
				end
			end
			default: begin
				// ignore bytes until the buffer ends
			end
		endcase

		// page finished: rearm on a good CRC, otherwise drop the rest
		if (res.valid && (phase_q != PH_HEADER || hidx_q >= SEG_POS)) begin
			if (res.status == ST_OK) begin
				phase_d = PH_HEADER;
				hidx_d  = 9'd0;
			end else begin
				phase_d = PH_IGNORE;
			end
		end

		if (last_byte) begin
			if (!res.valid && phase_d != PH_IGNORE
			    && !(phase_d == PH_HEADER && hidx_d == 9'd0)) begin
				res.valid         = 1'b1;
				res.status        = ST_TRUNC;
				res.header_length = (phase_d == PH_LACING || phase_d == PH_BODY) ? hlen_d : 9'd0;
				res.body_length   = (phase_d == PH_BODY) ? bsum_d : 16'd0;
			end
			phase_d  = PH_HEADER;
			hidx_d   = 9'd0;
			seg_d    = 8'd0;
			bsum_d   = 16'd0;
			bleft_d  = 16'd0;
			crc_d    = 32'd0;
			stored_d = 32'd0;
			pos_d    = '0;
			pstart_d = '0;
		end else begin
			pos_d = (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			hidx_q   <= 9'd0;
			seg_q    <= 8'd0;
			bsum_q   <= 16'd0;
			bleft_q  <= 16'd0;
			crc_q    <= 32'd0;
			stored_q <= 32'd0;
			pos_q    <= '0;
			pstart_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			hidx_q   <= hidx_d;
			seg_q    <= seg_d;
			bsum_q   <= bsum_d;
			bleft_q  <= bleft_d;
			crc_q    <= crc_d;
			stored_q <= stored_d;
			pos_q    <= pos_d;
			pstart_q <= pstart_d;
		end
	end

endmodule

// File: hdl/ogg_page_validator.sv
// ----------------------------------------------------------------------------
// ogg_page_validator
// Streams a byte buffer, splits it into Ogg pages and reports each page.
// ----------------------------------------------------------------------------
// Input channel: one buffer byte per beat (data_byte), last_byte marks the
// final byte of a buffer. Output channel: one beat per finished page (status
// ok or crc mismatch), at the first capture or version error, or on a
// buffer that ends inside a page (truncated). Bytes after an error are
// dropped until last_byte. A buffer ending on a page boundary adds no beat.
// Path: the byte that completes a result is held in the input register, and
// the result is then stored in the result register, which drives the output.
// Throughput: one byte per cycle unless out_ready stalls; per byte, a single
// 8-step CRC update plus counter updates run between the two registers.
// Reset: all parse state clears, the next byte starts a buffer at offset 0,
// both registers empty. Stall: the result beat holds in the output register;
// one more byte advances into the input register, and if that byte cannot
// advance, in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
module ogg_page_validator
	import ogg_pv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       status,
	output logic [POS_W-1:0] page_offset,
	output logic [8:0]       header_length,
	output logic [15:0]      body_length,
	output logic             buffer_done
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result register
	res_t res_s2;
	res_t res;

	logic advance;

	// the byte in the input register is processed whenever the result
	// register is empty or its beat is being taken this cycle
	assign advance  = valid_s1 && (!res_s2.valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// hold the payload while the stage stalls
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	ogg_pv_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (advance) begin
			res_s2 <= res;
		end else if (out_ready) begin
			res_s2.valid <= 1'b0;
		end
	end

	assign out_valid     = res_s2.valid;
	assign status        = res_s2.status;
	assign page_offset   = res_s2.page_offset;
	assign header_length = res_s2.header_length;
	assign body_length   = res_s2.body_length;
	assign buffer_done   = res_s2.buffer_done;

	// input backs up only when a byte waits behind a stalled result
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid && !out_ready))
		else $error("input stalled without a blocked result");

	// header and version errors carry no lengths
	a_err_lengths: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_CAPTURE || status == ST_VERSION))
		|-> (header_length == 9'd0 && body_length == 16'd0))
		else $error("error result with nonzero lengths");

	// a good page always has a full fixed header
	a_ok_header: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OK) |-> (header_length >= HDR_FIXED))
		else $error("ok result with short header length");

	// truncation is only reported with the buffer's last byte
	a_trunc_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_TRUNC) |-> buffer_done)
		else $error("truncation reported before the end of the buffer");

endmodule
